// File: src/sll_pkg.sv
// shared types and constants for the list insert, delete and find core
package sll_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [4:0]         position;
    logic signed [31:0] item_value;
  } in_t;

  typedef struct packed {
    status_t    status;
    logic [3:0] found_index;
    logic [4:0] length_after;
  } out_t;

  typedef struct packed {
    logic load;
    logic shift_up;
    logic shift_dn;
  } cell_ctrl_t;

endpackage

// File: src/sll_cell.sv
// one list cell: holds an entry, shifts to or from its neighbours, compares with the key
module sll_cell (
  input  logic                clk,
  input  sll_pkg::cell_ctrl_t ctrl,
  input  logic signed [31:0]  left_val,
  input  logic signed [31:0]  right_val,
  input  logic signed [31:0]  new_val,
  input  logic signed [31:0]  key,
  output logic signed [31:0]  value,
  output logic                match
);

  logic signed [31:0] value_r;
  logic signed [31:0] value_nxt;

  always_comb begin
    priority if (ctrl.load) begin
      value_nxt = new_val;
    end else if (ctrl.shift_up) begin
      value_nxt = left_val;
    end else if (ctrl.shift_dn) begin
      value_nxt = right_val;
    end else begin
      value_nxt = value_r;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;
  assign match = (value_r == key);

endmodule

// File: src/sll_penc.sv
// lowest-index priority encoder over the registered match vector
module sll_penc #(
  parameter int N  = 16,
  parameter int IW = (N > 1) ? $clog2(N) : 1
) (
  input  logic [N-1:0]  req,
  output logic          hit,
  output logic [IW-1:0] idx
);

  always_comb begin
    idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (req[i]) begin
        idx = IW'(i);
      end
    end
  end

  assign hit = |req;

endmodule

// File: src/sequential_list_insert_delete_find_core.sv
// top level of the list insert, delete and find core
//
// An ordered list of up to CAPACITY signed 32-bit entries held in a row of
// cells, one entry per cell, with an entry count.
// Input channel: a transaction is taken at a rising edge where start is high
// and busy is low; in_data carries operation, position and item_value.
// Insert at a position from 0 to the count, when not full, moves later entries up one cell;
// delete at a position below the count moves later entries down one cell;
// both shift the cells from the position on in the cycle of acceptance. Find compares every
// cell with the value in that same cycle.
// Result channel: out_valid is high for exactly one cycle per result, with status,
// found_index and length_after, registered first in the s1 registers and then in the output register.
// The output register takes the lowest-index search over the registered match bits.
// Throughput: one transaction per cycle; busy is high only during reset and in the
// cycle that follows it, so back-to-back transactions are taken without a gap.
// Reset empties the list and drops any result in flight. The receiver cannot
// stall: every result is taken in its strobe cycle.
module sequential_list_insert_delete_find_core #(
  parameter int CAPACITY = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  sll_pkg::in_t  in_data,
  output logic          out_valid,
  output sll_pkg::out_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 5) ? CW : 5;
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic          busy_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          s1_valid_r;
  logic          s1_find_r;
  sll_pkg::status_t s1_status_r, s1_status_nxt;
  logic [CAPACITY-1:0] s1_match_r, match_vec;
  logic [CW-1:0] s1_len_r;
  logic          out_valid_r;
  sll_pkg::out_t out_data_r, out_data_nxt;

  logic          accept;
  logic [PW-1:0] pos_ext, cnt_ext;
  logic          full, ins_go, del_go, is_ins, is_del, is_find;
  logic          enc_hit;
  logic [IW-1:0] enc_idx;

  logic signed [31:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0] cell_match;

  assign accept  = start && !busy_r;
  assign pos_ext = PW'(in_data.position);
  assign cnt_ext = PW'(count_r);
  assign full    = (count_r == CW'(CAPACITY));
  assign is_ins  = (in_data.operation == sll_pkg::OP_INSERT);
  assign is_del  = (in_data.operation == sll_pkg::OP_DELETE);
  assign is_find = (in_data.operation == sll_pkg::OP_FIND);
  assign ins_go  = accept && is_ins && !full && !(pos_ext > cnt_ext);
  assign del_go  = accept && is_del && (pos_ext < cnt_ext);

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sll_pkg::cell_ctrl_t ctrl;
    logic signed [31:0]  left_val, right_val;

    assign ctrl.load     = ins_go && (PW'(i) == pos_ext);
    assign ctrl.shift_up = ins_go && (PW'(i) > pos_ext);
    assign ctrl.shift_dn = del_go && !(PW'(i) < pos_ext);

    if (i == 0) begin : g_first
      assign left_val = in_data.item_value;
    end else begin : g_left
      assign left_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_right
      assign right_val = cell_val[i+1];
    end

    sll_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .left_val  (left_val),
      .right_val (right_val),
      .new_val   (in_data.item_value),
      .key       (in_data.item_value),
      .value     (cell_val[i]),
      .match     (cell_match[i])
    );

    assign match_vec[i] = cell_match[i] && (CW'(i) < count_r);
  end

  always_comb begin
    count_nxt = count_r;
    if (ins_go) begin
      count_nxt = count_r + CW'(1);
    end else if (del_go) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    s1_status_nxt = sll_pkg::ST_OK;
    priority if (is_ins && full) begin
      s1_status_nxt = sll_pkg::ST_FULL;
    end else if (is_ins && (pos_ext > cnt_ext)) begin
      s1_status_nxt = sll_pkg::ST_BADPOS;
    end else if (is_del && !(pos_ext < cnt_ext)) begin
      s1_status_nxt = sll_pkg::ST_BADPOS;
    end else begin
      s1_status_nxt = sll_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      count_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      count_r     <= count_nxt;
      s1_valid_r  <= accept;
      out_valid_r <= s1_valid_r;
    end
  end

  // transaction payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_find_r   <= is_find;
      s1_status_r <= s1_status_nxt;
      s1_match_r  <= match_vec;
      s1_len_r    <= count_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  sll_penc #(
    .N  (CAPACITY),
    .IW (IW)
  ) u_penc (
    .req (s1_match_r),
    .hit (enc_hit),
    .idx (enc_idx)
  );

  always_comb begin
    out_data_nxt.status       = s1_status_r;
    out_data_nxt.found_index  = '0;
    out_data_nxt.length_after = 5'(s1_len_r);
    if (s1_find_r) begin
      if (enc_hit) begin
        out_data_nxt.status      = sll_pkg::ST_OK;
        out_data_nxt.found_index = 4'(enc_idx);
      end else begin
        out_data_nxt.status = sll_pkg::ST_NOTFOUND;
      end
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: src/sll_chk.sv
// port checker for the list core, attached to the top level by bind
module sll_chk #(
  parameter int CAPACITY = 16
) (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input sll_pkg::out_t out_data
);

  logic [4:0] prev_len_r;
  logic [4:0] len_step;

  always_ff @(posedge clk) begin
    prev_len_r <= out_data.length_after;
  end

  assign len_step = out_data.length_after - prev_len_r;

  // every accepted transaction gives a result
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("result missing two cycles after a transaction");

  // no result without a transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without a transaction");

  // a transaction with a status other than OK reports index zero
  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != sll_pkg::ST_OK) |-> (out_data.found_index == 4'd0))
    else $error("found_index set on a failed transaction");

  // length moves by at most one between back-to-back results
  a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(out_valid)) |->
      (len_step == 5'd0 || len_step == 5'd1 || len_step == 5'd31))
    else $error("length jumped by more than one");

  // the list never holds more than its capacity
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_data.length_after) <= CAPACITY))
    else $error("length beyond capacity");

endmodule

bind sequential_list_insert_delete_find_core sll_chk #(
  .CAPACITY (CAPACITY)
) u_sll_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// File: tb/list_result_checker.sv
// checker that predicts each list result and compares it with the core's output
module list_result_checker #(
  parameter int CAPACITY = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  sll_pkg::in_t  in_data,
  input  logic          out_valid,
  input  sll_pkg::out_t out_data,
  output int            mismatches,
  output int            awaiting,
  output int            checked,
  output logic [4:0]    list_len
);

  logic signed [31:0] entries [CAPACITY];
  logic [4:0]         entry_total;
  sll_pkg::out_t      awaited_results [$];

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic sll_pkg::out_t apply_list_op(sll_pkg::in_t item);
    sll_pkg::out_t res;
    int            idx;
    bit            hit;
    res.status      = sll_pkg::ST_OK;
    res.found_index = '0;
    hit             = 1'b0;
    unique case (item.operation)
      sll_pkg::OP_INSERT: begin
        if (entry_total >= CAPACITY) begin
          res.status = sll_pkg::ST_FULL;
        end else if (item.position > entry_total) begin
          res.status = sll_pkg::ST_BADPOS;
        end else begin
          for (idx = int'(entry_total); idx > int'(item.position); idx--) begin
            entries[idx] = entries[idx-1];
          end
          entries[item.position] = item.item_value;
          entry_total++;
        end
      end
      sll_pkg::OP_DELETE: begin
        if (item.position >= entry_total) begin
          res.status = sll_pkg::ST_BADPOS;
        end else begin
          for (idx = int'(item.position); idx + 1 < int'(entry_total); idx++) begin
            entries[idx] = entries[idx+1];
          end
          entry_total--;
        end
      end
      sll_pkg::OP_FIND: begin
        res.status = sll_pkg::ST_NOTFOUND;
        for (idx = 0; idx < int'(entry_total); idx++) begin
          if (!hit && entries[idx] == item.item_value) begin
            hit             = 1'b1;
            res.status      = sll_pkg::ST_OK;
            res.found_index = idx[3:0];
          end
        end
      end
      default: ;
    endcase
    res.length_after = entry_total;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    sll_pkg::out_t want;
    if (!rst_n) begin
      awaited_results.delete();
      entry_total = '0;
      mismatches  = 0;
      checked     = 0;
    end else begin
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          report("result with no transaction awaiting it");
        end else begin
          want = awaited_results.pop_front();
          checked++;
          if (out_data.status !== want.status)
            report($sformatf("status got %0d expected %0d",
                             int'(out_data.status), int'(want.status)));
          if (out_data.found_index !== want.found_index)
            report($sformatf("found_index got %0d expected %0d",
                             out_data.found_index, want.found_index));
          if (out_data.length_after !== want.length_after)
            report($sformatf("length_after got %0d expected %0d",
                             out_data.length_after, want.length_after));
        end
      end
      if (start && !busy) begin
        awaited_results.push_back(apply_list_op(in_data));
      end
    end
    awaiting = awaited_results.size();
    list_len <= entry_total;
  end

endmodule

// File: tb/testbench.sv
// top of the list core testbench: clock, reset, stimulus and verdict
module testbench;

  localparam int         LIST_CAP     = 16;
  localparam int         RANDOM_ITEMS = 500;
  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         MODE_GROW    = 0;
  localparam int         MODE_SHRINK  = 1;
  localparam int         MODE_MIXED   = 2;

  logic          clk     = 1'b0;
  logic          rst_n   = 1'b0;
  logic          start   = 1'b0;
  sll_pkg::in_t  in_data = '0;
  logic          busy;
  logic          out_valid;
  sll_pkg::out_t out_data;

  int         mismatches;
  int         awaiting;
  int         checked;
  logic [4:0] model_len;

  int                 op_tally [4] = '{default: 0};
  logic signed [31:0] value_pool [8];

  always #5 clk = ~clk;

  sequential_list_insert_delete_find_core #(
    .CAPACITY(LIST_CAP)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  list_result_checker #(
    .CAPACITY(LIST_CAP)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .mismatches(mismatches),
    .awaiting  (awaiting),
    .checked   (checked),
    .list_len  (model_len)
  );

  task automatic send_item(logic [1:0] op, logic [4:0] pos, logic signed [31:0] val);
    sll_pkg::in_t item;
    item.operation  = op;
    item.position   = pos;
    item.item_value = val;
    in_data <= item;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    op_tally[op]++;
  endtask

  task automatic pause(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [1:0] pick_op(int mode);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return OP_UNUSED;
    unique case (mode)
      MODE_GROW:
        return (r < 70) ? sll_pkg::OP_INSERT : (r < 85) ? sll_pkg::OP_FIND : sll_pkg::OP_DELETE;
      MODE_SHRINK:
        return (r < 65) ? sll_pkg::OP_DELETE : (r < 82) ? sll_pkg::OP_FIND : sll_pkg::OP_INSERT;
      default:
        return (r < 40) ? sll_pkg::OP_INSERT : (r < 70) ? sll_pkg::OP_FIND : sll_pkg::OP_DELETE;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  initial begin : stimulus
    int         issued;
    int         mode;
    int         burst_len;
    int         len;
    bit         quiet;
    logic [1:0] op;
    logic [4:0] pos;

    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = -32'sd1;
    value_pool[3] = 32'sd0;
    value_pool[4] = 32'sd1;
    value_pool[5] = $urandom;
    value_pool[6] = $urandom;
    value_pool[7] = $urandom;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // empty list, then edges of insert, delete and find, and an unused operation code
    send_item(sll_pkg::OP_FIND,   5'd0,  32'sd0);
    send_item(sll_pkg::OP_DELETE, 5'd0,  32'sd0);
    send_item(sll_pkg::OP_DELETE, 5'd31, -32'sd1);
    send_item(sll_pkg::OP_INSERT, 5'd1,  32'sd5);
    send_item(sll_pkg::OP_INSERT, 5'd0,  32'sh8000_0000);
    send_item(sll_pkg::OP_INSERT, 5'd1,  32'sh7fff_ffff);
    send_item(sll_pkg::OP_INSERT, 5'd1,  -32'sd1);
    send_item(sll_pkg::OP_INSERT, 5'd3,  32'sd0);
    send_item(sll_pkg::OP_INSERT, 5'd5,  32'sd1);
    send_item(sll_pkg::OP_INSERT, 5'd31, 32'sd1);
    send_item(sll_pkg::OP_FIND,   5'd31, -32'sd1);
    send_item(sll_pkg::OP_FIND,   5'd0,  32'sh7fff_ffff);
    send_item(sll_pkg::OP_FIND,   5'd0,  32'sd0);
    send_item(sll_pkg::OP_FIND,   5'd0,  32'sd12345);
    pause(3);
    send_item(sll_pkg::OP_INSERT, 5'd0,  -32'sd1);
    send_item(sll_pkg::OP_FIND,   5'd0,  -32'sd1);
    send_item(OP_UNUSED,          5'd7,  32'sh5a5a_a5a5);
    send_item(sll_pkg::OP_DELETE, 5'd5,  32'sd0);
    send_item(sll_pkg::OP_DELETE, 5'd4,  32'sd0);
    pause(1);
    send_item(sll_pkg::OP_DELETE, 5'd0,  32'sd0);
    send_item(sll_pkg::OP_DELETE, 5'd1,  32'sd0);
    send_item(sll_pkg::OP_FIND,   5'd0,  32'sh8000_0000);
    pause(5);

    // bursts that fill, drain and churn the list
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      mode      = $urandom_range(MODE_GROW, MODE_MIXED);
      burst_len = $urandom_range(8, 40);
      quiet     = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < burst_len; k++) begin
        op  = pick_op(mode);
        len = int'(model_len);
        if ($urandom_range(0, 6) == 0 || op == sll_pkg::OP_FIND || op == OP_UNUSED)
          pos = 5'($urandom_range(0, 31));
        else if (op == sll_pkg::OP_INSERT)
          pos = 5'($urandom_range(0, len));
        else
          pos = (len == 0) ? 5'd0 : 5'($urandom_range(0, len - 1));
        send_item(op, pos, pick_value());
        issued++;
        if (!quiet) pause(pick_gap());
      end
    end
    start <= 1'b0;

    @(posedge clk);
    for (int w = 0; w < 1000 && awaiting != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d transactions: insert %0d, delete %0d, find %0d, unused code %0d",
             op_tally[0] + op_tally[1] + op_tally[2] + op_tally[3],
             op_tally[sll_pkg::OP_INSERT], op_tally[sll_pkg::OP_DELETE],
             op_tally[sll_pkg::OP_FIND], op_tally[OP_UNUSED]);
    $display("%0d results checked, %0d mismatches, %0d still outstanding",
             checked, mismatches, awaiting);
    if (mismatches == 0 && awaiting == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("run stopped on timeout");
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: filelist.f
src/sll_pkg.sv
src/sll_cell.sv
src/sll_penc.sv
src/sequential_list_insert_delete_find_core.sv
src/sll_chk.sv
tb/list_result_checker.sv
tb/testbench.sv
